// ----- rtl/fdmd_pkg.sv -----
package fdmd_pkg;

    localparam int LANES            = 8;
    localparam int PIX_W            = 8;
    localparam int MAX_FRAME_GROUPS = 32768;
    localparam int GIDX_W           = $clog2(MAX_FRAME_GROUPS);
    localparam int GRP_W            = 16;
    localparam int MAX_HISTORY      = 64;
    localparam int RIDX_W           = $clog2(MAX_HISTORY);
    localparam int HIST_W           = 7;
    localparam int GSUM_W           = PIX_W + $clog2(LANES) + 1;
    localparam int SAD_W            = 26;
    localparam int TOTAL_W          = 32;
    localparam int THR_W            = 16;
    localparam int RUN_W            = 8;
    localparam int TICK_W           = 32;
    localparam int FULL_SCALE       = LANES * 255;
    localparam int FS_W             = $clog2(FULL_SCALE + 1);
    localparam int A_W              = THR_W + HIST_W;
    localparam int B_W              = GRP_W + FS_W;
    localparam int RHS_W            = A_W + B_W;
    localparam int ADDR_W           = 5;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_STOP  = 2'd2;

    localparam logic [2:0] REG_GROUPS  = 3'd0;
    localparam logic [2:0] REG_HIST    = 3'd1;
    localparam logic [2:0] REG_THR     = 3'd2;
    localparam logic [2:0] REG_START   = 3'd3;
    localparam logic [2:0] REG_PRESTOP = 3'd4;
    localparam logic [2:0] REG_CANCEL  = 3'd5;
    localparam logic [2:0] REG_STOP    = 3'd6;

    typedef struct packed {
        logic [HIST_W-1:0] history_len;
        logic [THR_W-1:0]  threshold;
        logic [RUN_W-1:0]  start_count;
        logic [RUN_W-1:0]  prestop_frames;
        logic [RUN_W-1:0]  cancel_frames;
        logic [TICK_W-1:0] stop_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       motion_event;
        logic [SAD_W-1:0] frame_sad;
        logic             motion_on;
    } t_result;

endpackage

// ----- rtl/fdmd_lane.sv -----
module fdmd_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [fdmd_pkg::PIX_W-1:0] i_cur,
    input  logic [fdmd_pkg::PIX_W-1:0] i_prev,
    output logic [fdmd_pkg::PIX_W-1:0] o_diff
);
    import fdmd_pkg::*;

    logic [PIX_W-1:0] r_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= (i_cur > i_prev) ? i_cur - i_prev : i_prev - i_cur;
        end
    end

    assign o_diff = r_diff;

endmodule

// ----- rtl/fdmd_merge.sv -----
module fdmd_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [fdmd_pkg::LANES-1:0][fdmd_pkg::PIX_W-1:0] i_diff,
    input  logic                                          i_valid,
    input  logic                                          i_last,
    output logic                                          o_done,
    output logic [fdmd_pkg::SAD_W-1:0]                    o_sad
);
    import fdmd_pkg::*;

    logic [SAD_W-1:0]  r_acc;
    logic [SAD_W-1:0]  r_sad;
    logic              r_done;
    logic [GSUM_W-1:0] sum;
    logic [SAD_W-1:0]  n_acc;

    always_comb begin
        sum = '0;
        for (int k = 0; k < LANES; k++) begin
            sum = sum + GSUM_W'(i_diff[k]);
        end
        n_acc = r_acc + SAD_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid && i_last;
            if (i_valid) begin
                r_acc <= i_last ? '0 : n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_last) begin
            r_sad <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_sad  = r_sad;

endmodule

// ----- rtl/fdmd_frame_end.sv -----
module fdmd_frame_end (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fdmd_pkg::t_cfg                i_cfg,
    input  logic [fdmd_pkg::GRP_W-1:0]    i_groups,
    input  logic                          i_start,
    input  logic [fdmd_pkg::SAD_W-1:0]    i_sad,
    input  logic [fdmd_pkg::TICK_W-1:0]   i_now,
    input  logic                          i_take,
    output logic                          o_valid,
    output fdmd_pkg::t_result             o_result
);
    import fdmd_pkg::*;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_WRITE = 3'd1;
    localparam logic [2:0] F_SUM   = 3'd2;
    localparam logic [2:0] F_MUL1  = 3'd3;
    localparam logic [2:0] F_MUL2  = 3'd4;
    localparam logic [2:0] F_DEC   = 3'd5;
    localparam logic [2:0] F_OUT   = 3'd6;

    logic [SAD_W-1:0] ring [MAX_HISTORY];
    logic [SAD_W-1:0] r_q;

    logic [2:0]        r_state, n_state;
    logic [SAD_W-1:0]  r_sad;
    logic [RIDX_W-1:0] r_wi, n_wi;
    logic [HIST_W-1:0] r_fill, n_fill;
    logic [HIST_W-1:0] r_i;
    logic              r_rdv;
    logic [TOTAL_W-1:0] r_total;
    logic [A_W-1:0]    r_a;
    logic [B_W-1:0]    r_b;
    logic [RHS_W-1:0]  r_rhs;
    logic              r_active, n_active;
    logic              r_prestop, n_prestop;
    logic [TICK_W-1:0] r_ptime, n_ptime;
    logic [RUN_W-1:0]  r_high, n_high;
    logic [RUN_W-1:0]  r_low, n_low;
    logic [1:0]        r_event, n_event;

    logic [HIST_W-1:0] hl;
    logic [RIDX_W-1:0] wi_eff;
    logic [HIST_W-1:0] fill_eff;
    logic [RHS_W-1:0]  lhs;
    logic              high;

    always_comb begin
        hl = i_cfg.history_len;
        if (hl == '0) hl = HIST_W'(1);
        if (hl > HIST_W'(MAX_HISTORY)) hl = HIST_W'(MAX_HISTORY);
        wi_eff   = ({1'b0, r_wi} >= hl) ? '0 : r_wi;
        fill_eff = (r_fill > hl) ? hl : r_fill;
        lhs      = RHS_W'({r_total, 16'h0});
        high     = lhs > r_rhs;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_WRITE) begin
            ring[wi_eff] <= r_sad;
        end
        r_q <= ring[r_i[RIDX_W-1:0]];
    end

    // frame decision
    always_comb begin
        n_state   = r_state;
        n_wi      = r_wi;
        n_fill    = r_fill;
        n_active  = r_active;
        n_prestop = r_prestop;
        n_ptime   = r_ptime;
        n_high    = r_high;
        n_low     = r_low;
        n_event   = r_event;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) n_state = F_WRITE;
            end
            F_WRITE: begin
                n_wi    = ({1'b0, wi_eff} + 1'b1 >= hl) ? '0 : wi_eff + 1'b1;
                n_fill  = (fill_eff < hl) ? fill_eff + 1'b1 : fill_eff;
                n_state = F_SUM;
            end
            F_SUM: begin
                if (r_i >= r_fill && !r_rdv) n_state = F_MUL1;
            end
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = F_DEC;
            F_DEC: begin
                n_event = EV_NONE;
                n_state = F_OUT;
                if (!r_active) begin
                    n_high = high ? ((r_high == '1) ? r_high : r_high + 1'b1) : '0;
                    if (n_high >= i_cfg.start_count) begin
                        n_active  = 1'b1;
                        n_high    = '0;
                        n_low     = '0;
                        n_prestop = 1'b0;
                        n_event   = EV_START;
                    end
                end else if (!r_prestop) begin
                    if (!high) begin
                        n_low = (r_low == '1) ? r_low : r_low + 1'b1;
                        if (n_low >= i_cfg.prestop_frames) begin
                            n_prestop = 1'b1;
                            n_ptime   = i_now;
                        end
                    end else begin
                        n_low = '0;
                    end
                end else if (high) begin
                    n_high = (r_high == '1) ? r_high : r_high + 1'b1;
                    if (n_high >= i_cfg.cancel_frames) begin
                        n_prestop = 1'b0;
                        n_high    = '0;
                        n_low     = '0;
                    end
                end else if (i_now - r_ptime >= i_cfg.stop_ticks) begin
                    n_active  = 1'b0;
                    n_prestop = 1'b0;
                    n_event   = EV_STOP;
                end
            end
            F_OUT: begin
                if (i_take) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_wi      <= '0;
            r_fill    <= '0;
            r_active  <= 1'b0;
            r_prestop <= 1'b0;
            r_ptime   <= '0;
            r_high    <= '0;
            r_low     <= '0;
            r_event   <= EV_NONE;
            r_rdv     <= 1'b0;
            r_i       <= '0;
        end else begin
            r_state   <= n_state;
            r_wi      <= n_wi;
            r_fill    <= n_fill;
            r_active  <= n_active;
            r_prestop <= n_prestop;
            r_ptime   <= n_ptime;
            r_high    <= n_high;
            r_low     <= n_low;
            r_event   <= n_event;
            r_rdv     <= (r_state == F_SUM) && (r_i < r_fill);
            if (r_state == F_WRITE) begin
                r_i <= '0;
            end else if (r_state == F_SUM && r_i < r_fill) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_start) begin
            r_sad <= i_sad;
        end
        if (r_state == F_WRITE) begin
            r_total <= '0;
        end else if (r_state == F_SUM && r_rdv) begin
            r_total <= r_total + TOTAL_W'(r_q);
        end
        if (r_state == F_MUL1) begin
            r_a <= A_W'(i_cfg.threshold) * A_W'(r_fill);
            r_b <= B_W'(i_groups) * B_W'(FULL_SCALE);
        end
        if (r_state == F_MUL2) begin
            r_rhs <= r_a * r_b;
        end
    end

    assign o_valid                = (r_state == F_OUT);
    assign o_result.motion_event  = r_event;
    assign o_result.frame_sad     = r_sad;
    assign o_result.motion_on     = r_active;

endmodule

// ----- rtl/frame_diff_motion_detector.sv -----
// Frame-difference motion detector. Each item carries eight luma pixels and the
// current timestamp; the block sums absolute differences against the previous
// frame, kept in an on-chip frame store, and emits one result per completed frame.
// Within a frame one item is taken per cycle, through a read-then-write pipeline
// on the frame store and eight difference lanes. After a frame's last item the
// input stalls while the frame decision sweeps the history ring memory one
// entry a cycle and forms the threshold product in two multiply steps, and until
// the frame's result is taken into the output register.
// The frame store needs no clearing pass: a fill mark treats unwritten groups
// as zero. Registers are to be written over the APB port only while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
module frame_diff_motion_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [95:0]                   i_s_axis_tdata,  // pixel_group, now_ticks
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [31:0]                   o_m_axis_tdata,  // motion_event, frame_sad, motion_on
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [fdmd_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);
    import fdmd_pkg::*;

    localparam int GW = LANES * PIX_W;

    logic [GRP_W-1:0]  r_groups;
    t_cfg              r_cfg;

    logic [GW-1:0]     frame_mem [MAX_FRAME_GROUPS];
    logic [GW-1:0]     r_mem_q;

    logic [GIDX_W-1:0] r_gidx;
    logic [GIDX_W:0]   r_pfill;
    logic              r_busy;
    logic [TICK_W-1:0] r_now;

    logic              r_s1v;
    logic              r_s1_last;
    logic              r_s1_known;
    logic [GIDX_W-1:0] r_s1_idx;
    logic [GW-1:0]     r_s1_pix;
    logic              r_s2v;
    logic              r_s2_last;

    logic              r_ovalid;
    t_result           r_out;

    logic [GRP_W-1:0]  groups_eff;
    logic              accept;
    logic              last;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic [LANES-1:0][PIX_W-1:0] diffs;
    logic              m_done;
    logic [SAD_W-1:0]  m_sad;
    logic              fe_valid;
    t_result           fe_result;
    logic              slot_free;
    logic              take;

    always_comb begin
        groups_eff = r_groups;
        if (groups_eff == '0) groups_eff = GRP_W'(1);
        if (groups_eff > GRP_W'(MAX_FRAME_GROUPS)) groups_eff = GRP_W'(MAX_FRAME_GROUPS);
    end

    assign o_s_axis_tready = !r_busy;
    assign accept          = i_s_axis_tvalid && !r_busy;
    assign last            = ({1'b0, r_gidx} + 1'b1) >= (GIDX_W + 1)'(groups_eff);

    // config port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups            <= GRP_W'(MAX_FRAME_GROUPS);
            r_cfg.history_len   <= HIST_W'(8);
            r_cfg.threshold     <= THR_W'(1311);
            r_cfg.start_count   <= RUN_W'(3);
            r_cfg.prestop_frames <= RUN_W'(30);
            r_cfg.cancel_frames <= RUN_W'(3);
            r_cfg.stop_ticks    <= TICK_W'(1000);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GROUPS:  r_groups             <= i_pwdata[GRP_W-1:0];
                REG_HIST:    r_cfg.history_len    <= i_pwdata[HIST_W-1:0];
                REG_THR:     r_cfg.threshold      <= i_pwdata[THR_W-1:0];
                REG_START:   r_cfg.start_count    <= i_pwdata[RUN_W-1:0];
                REG_PRESTOP: r_cfg.prestop_frames <= i_pwdata[RUN_W-1:0];
                REG_CANCEL:  r_cfg.cancel_frames  <= i_pwdata[RUN_W-1:0];
                REG_STOP:    r_cfg.stop_ticks     <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (cfg_idx)
            REG_GROUPS:  o_prdata = 32'(r_groups);
            REG_HIST:    o_prdata = 32'(r_cfg.history_len);
            REG_THR:     o_prdata = 32'(r_cfg.threshold);
            REG_START:   o_prdata = 32'(r_cfg.start_count);
            REG_PRESTOP: o_prdata = 32'(r_cfg.prestop_frames);
            REG_CANCEL:  o_prdata = 32'(r_cfg.cancel_frames);
            REG_STOP:    o_prdata = r_cfg.stop_ticks;
            default:     o_prdata = '0;
        endcase
    end

    // frame store, read at accept and written in the following cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= frame_mem[r_gidx];
        end
        if (r_s1v) begin
            frame_mem[r_s1_idx] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gidx    <= '0;
            r_pfill   <= '0;
            r_busy    <= 1'b0;
            r_s1v     <= 1'b0;
            r_s2v     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_s1v <= accept;
            r_s2v <= r_s1v;
            if (accept) begin
                r_gidx <= last ? '0 : r_gidx + 1'b1;
                if ({1'b0, r_gidx} >= r_pfill) r_pfill <= {1'b0, r_gidx} + 1'b1;
                if (last) r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_s_axis_tdata[GW-1:0];
            r_s1_idx   <= r_gidx;
            r_s1_last  <= last;
            r_s1_known <= {1'b0, r_gidx} < r_pfill;
            r_now      <= i_s_axis_tdata[GW +: TICK_W];
        end
        r_s2_last <= r_s1_last;
        if (take) begin
            r_out <= fe_result;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        fdmd_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (r_s1v),
            .i_cur  (r_s1_pix[k*PIX_W +: PIX_W]),
            .i_prev (r_s1_known ? r_mem_q[k*PIX_W +: PIX_W] : '0),
            .o_diff (diffs[k])
        );
    end

    fdmd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_diff  (diffs),
        .i_valid (r_s2v),
        .i_last  (r_s2_last),
        .o_done  (m_done),
        .o_sad   (m_sad)
    );

    assign slot_free = !r_ovalid || i_m_axis_tready;
    assign take      = fe_valid && slot_free;

    fdmd_frame_end u_frame_end (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_groups (groups_eff),
        .i_start  (m_done),
        .i_sad    (m_sad),
        .i_now    (r_now),
        .i_take   (slot_free),
        .o_valid  (fe_valid),
        .o_result (fe_result)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {3'b0, r_out.motion_on, r_out.frame_sad, r_out.motion_event};

endmodule

// ----- rtl/fdmd_checker.sv -----
module fdmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_pready
);
    import fdmd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] <= EV_STOP)
        else $error("bad event code");

    a_start_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == EV_START |-> o_m_axis_tdata[28])
        else $error("start without motion on");

    a_stop_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == EV_STOP |-> !o_m_axis_tdata[28])
        else $error("stop with motion on");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_pready)
        else $error("pready low");

endmodule

bind frame_diff_motion_detector fdmd_checker u_fdmd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_pready        (o_pready)
);
